// ===== sv/qvp_pkg.sv =====
package qvp_pkg;
    localparam int CntBits = 16;
    localparam int TimeBits = 16;
    localparam int AxisBits = 14;
    localparam logic [18:0] JerkCoef = 19'd378372;
    localparam logic [23:0] SegMax = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_JOY  = 2'd0,
        OP_FB   = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam logic [2:0] REG_TURN_SPD = 3'd0;
    localparam logic [2:0] REG_FWD_SPD  = 3'd1;
    localparam logic [2:0] REG_TURN_ACC = 3'd2;
    localparam logic [2:0] REG_TURN_JRK = 3'd3;
    localparam logic [2:0] REG_FWD_ACC  = 3'd4;
    localparam logic [2:0] REG_FWD_JRK  = 3'd5;
    localparam logic [2:0] REG_TICK     = 3'd6;

    // request to the shared divider / root unit
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [39:0] den;
    } t_div_req;

    function automatic logic signed [15:0] sat16(input logic signed [40:0] x);
        if (x > 41'sd32767) return 16'sh7fff;
        if (x < -41'sd32768) return 16'sh8000;
        return x[15:0];
    endfunction
endpackage

// ===== sv/qvp_divsqrt.sv =====
module qvp_divsqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qvp_pkg::t_div_req     i_req,
    output logic                  o_done,
    output logic [63:0]           o_result
);
    import qvp_pkg::*;

    // restoring division: one quotient bit per cycle
    // integer sqrt: one result bit per cycle
    logic [63:0] r_q;
    logic [64:0] r_rem;
    logic [63:0] r_num;
    logic [39:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_sqrt;
    logic [64:0] w_trial;
    logic [64:0] w_rs;
    logic [65:0] w_st;

    assign w_rs    = {r_rem[63:0], r_num[63]};
    assign w_trial = w_rs - {25'd0, r_den};
    assign w_st    = {r_rem[63:0], r_num[63:62]} - {r_q, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= i_req.is_sqrt ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    r_num <= {r_num[61:0], 2'b00};
                    if (!w_st[65]) begin
                        r_rem <= w_st[64:0];
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_num[63:62]};
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                end else begin
                    r_num <= {r_num[62:0], 1'b0};
                    if (!w_trial[64]) begin
                        r_rem <= w_trial;
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rs;
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_result = r_q;
endmodule

// ===== sv/qvp_mul.sv =====
module qvp_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [23:0] i_b,
    output logic signed [56:0] o_p
);
    // one registered multiply, shared by every product step
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

// ===== sv/quintic_velocity_profile.sv =====
// Two-axis quintic velocity profile shaper (turn and forward, Q3.12).
// Input channel i_valid/o_ready carries an operation and its fields:
// joystick (0) sets targets and arms a replan, feedback (1) stores start
// velocities, tick (2) advances the profile; code 3 is dropped.
// Output channel o_valid/i_ready carries one result per tick: the two
// commands and the replanned flag. Other operations give no result.
// A profile tick runs one division plus six registered multiplies before
// o_valid, a segment-end tick only the first multiply, a replan tick four
// divisions and two roots on the one shared shift-subtract unit. One item
// is in work at a time; for a tick o_ready is low from transfer until the
// result has been handed on, for a joystick until its targets are stored.
// A stalled receiver holds the result register and blocks new input.
// Reset (synchronous, active low) restores register defaults and clears
// the profile state but not the replanned flag; the block is ready the next cycle.
// Configuration writes through i_cfg_we/i_cfg_addr/i_cfg_data, idle only.
module quintic_velocity_profile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_operation,
    input  logic signed [15:0]  i_turn_axis,
    input  logic signed [15:0]  i_forward_axis,
    input  logic signed [15:0]  i_measured_turn_speed,
    input  logic signed [15:0]  i_measured_forward_speed,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_turn_command,
    output logic signed [15:0]  o_forward_command,
    output logic                o_replanned,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [15:0]         i_cfg_data
);
    import qvp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_JOY1, S_JOY2, S_JOY3,
        S_RP_AT, S_RP_AW, S_RP_JT, S_RP_JW, S_RP_ST, S_RP_SW, S_RP_NEXT,
        S_TK_MUL, S_TK_DIV, S_TK_DW, S_TK_S2, S_TK_S3, S_TK_B,
        S_TK_DT, S_TK_DF, S_TK_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [14:0] r_tspd, r_fspd, r_tacc, r_tjrk, r_facc, r_fjrk;
    logic [15:0] r_tick;
    logic signed [15:0] r_tgt_t, r_tgt_f, r_st_t, r_st_f, r_org_t, r_org_f;
    logic signed [15:0] r_ax_t, r_ax_f;
    logic signed [16:0] r_dl_t, r_dl_f;
    logic [23:0] r_seg;
    logic [CntBits-1:0] r_elap;
    logic r_pend;
    logic signed [15:0] r_last_t, r_last_f;
    logic r_axis;           // 0 turn, 1 forward
    logic [39:0] r_tmax;
    logic [39:0] r_tax;
    logic [16:0] r_s;
    logic signed [20:0] r_inner;
    logic signed [23:0] r_b;
    logic r_rep;

    t_div_req w_req;
    logic w_done;
    logic [63:0] w_res;
    logic signed [32:0] w_ma;
    logic signed [23:0] w_mb;
    logic signed [56:0] w_mp;
    logic signed [56:0] w_sh;

    logic [16:0] w_mag;
    logic [14:0] w_acc, w_jrk;
    logic [CntBits-1:0] w_elap_n;

    qvp_divsqrt u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_done(w_done), .o_result(w_res));
    qvp_mul u_mul (.i_clk, .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    always_comb begin
        logic signed [16:0] d;
        d = r_axis ? r_dl_f : r_dl_t;
        w_mag = d[16] ? 17'(-d) : 17'(d);
        w_acc = r_axis ? r_facc : r_tacc;
        w_jrk = r_axis ? r_fjrk : r_tjrk;
        if (w_acc == '0) w_acc = 15'd1;
        if (w_jrk == '0) w_jrk = 15'd1;
    end

    assign w_elap_n = (r_elap == {CntBits{1'b1}}) ? r_elap : r_elap + 1'b1;

    // previous product scaled back to Q.16, fed straight into the next multiply
    assign w_sh = w_mp >>> TimeBits;

    always_comb begin
        w_req = '0;
        w_ma  = '0;
        w_mb  = '0;
        case (r_state)
            S_RP_AT: begin
                w_req.start = 1'b1;
                w_req.num   = {28'd0, 20'(20'd15 * 20'(w_mag)), 16'd0};
                w_req.den   = {22'd0, w_acc, 3'd0};
            end
            S_RP_JT: begin
                w_req.start = 1'b1;
                w_req.num   = {{(64-52){1'b0}}, 36'(JerkCoef * w_mag), 16'd0};
                w_req.den   = {25'd0, w_jrk};
            end
            S_RP_ST: begin
                w_req.start   = 1'b1;
                w_req.is_sqrt = 1'b1;
                w_req.num     = w_res;
            end
            S_TK_DIV: begin
                w_req.start = 1'b1;
                w_req.num   = {w_mp[47:0], 16'd0};
                w_req.den   = {16'd0, r_seg};
            end
            S_JOY1: begin
                w_ma = 33'(signed'({1'b0, r_tspd}));
                w_mb = 24'(r_ax_t);
            end
            S_JOY2: begin
                w_ma = 33'(signed'({1'b0, r_fspd}));
                w_mb = 24'(r_ax_f);
            end
            S_TK_MUL: begin
                w_ma = 33'(signed'({1'b0, r_elap}));
                w_mb = 24'(signed'({1'b0, r_tick}));
            end
            S_TK_S2: begin
                w_ma = 33'(signed'({1'b0, r_s}));
                w_mb = 24'(signed'({1'b0, r_s}));
            end
            S_TK_S3: begin
                w_ma = 33'(signed'({1'b0, w_sh[16:0]}));
                w_mb = 24'(signed'({1'b0, r_s}));
            end
            S_TK_B: begin
                w_ma = 33'(signed'({1'b0, w_sh[16:0]}));
                w_mb = 24'(r_inner);
            end
            S_TK_DT: begin
                w_ma = 33'(r_dl_t);
                w_mb = w_sh[23:0];
            end
            S_TK_DF: begin
                w_ma = 33'(r_dl_f);
                w_mb = r_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tspd <= 15'd2048; r_fspd <= 15'd2867;
            r_tacc <= 15'd1024; r_tjrk <= 15'd410;
            r_facc <= 15'd1638; r_fjrk <= 15'd819;
            r_tick <= 16'd6554;
            r_tgt_t <= '0; r_tgt_f <= '0; r_st_t <= '0; r_st_f <= '0;
            r_org_t <= '0; r_org_f <= '0; r_dl_t <= '0; r_dl_f <= '0;
            r_seg <= '0; r_elap <= '0; r_pend <= 1'b0;
            r_last_t <= '0; r_last_f <= '0;
            o_valid <= 1'b0; o_ready <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TURN_SPD: r_tspd <= i_cfg_data[14:0];
                    REG_FWD_SPD:  r_fspd <= i_cfg_data[14:0];
                    REG_TURN_ACC: r_tacc <= i_cfg_data[14:0];
                    REG_TURN_JRK: r_tjrk <= i_cfg_data[14:0];
                    REG_FWD_ACC:  r_facc <= i_cfg_data[14:0];
                    REG_FWD_JRK:  r_fjrk <= i_cfg_data[14:0];
                    REG_TICK:     r_tick <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (t_op'(i_operation))
                            OP_JOY: begin
                                r_ax_t  <= i_turn_axis;
                                r_ax_f  <= i_forward_axis;
                                r_state <= S_JOY1;
                                o_ready <= 1'b0;
                            end
                            OP_FB: begin
                                r_st_t <= i_measured_turn_speed;
                                r_st_f <= i_measured_forward_speed;
                            end
                            OP_TICK: begin
                                o_ready <= 1'b0;
                                if (r_pend) begin
                                    r_pend  <= 1'b0;
                                    r_org_t <= r_st_t;
                                    r_org_f <= r_st_f;
                                    r_dl_t  <= 17'(r_tgt_t) - 17'(r_st_t);
                                    r_dl_f  <= 17'(r_tgt_f) - 17'(r_st_f);
                                    r_elap  <= '0;
                                    r_axis  <= 1'b0;
                                    r_tmax  <= '0;
                                    r_state <= S_RP_AT;
                                end else begin
                                    r_elap  <= w_elap_n;
                                    r_state <= S_TK_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // axes were latched at transfer
                S_JOY1: r_state <= S_JOY2;
                S_JOY2: begin
                    r_tgt_t <= sat16(41'(w_mp >>> AxisBits));
                    r_state <= S_JOY3;
                end
                S_JOY3: begin
                    r_tgt_f <= sat16(41'(w_mp >>> AxisBits));
                    r_pend  <= 1'b1;
                    r_state <= S_IDLE;
                    o_ready <= 1'b1;
                end
                S_RP_AT: r_state <= S_RP_AW;
                S_RP_AW: if (w_done) begin
                    r_tax   <= w_res[39:0];
                    r_state <= S_RP_JT;
                end
                S_RP_JT: r_state <= S_RP_JW;
                S_RP_JW: if (w_done) r_state <= S_RP_ST;
                S_RP_ST: r_state <= S_RP_SW;
                S_RP_SW: if (w_done) begin
                    if (w_res[39:0] > r_tax) r_tax <= w_res[39:0];
                    r_state <= S_RP_NEXT;
                end
                S_RP_NEXT: begin
                    if (r_axis) begin
                        if (r_tax > r_tmax) r_tmax <= r_tax;
                        r_state <= S_TK_FIN;
                        r_rep   <= 1'b1;
                    end else begin
                        r_tmax  <= r_tax;
                        r_axis  <= 1'b1;
                        r_state <= S_RP_AT;
                    end
                end
                S_TK_MUL: r_state <= S_TK_DIV;
                S_TK_DIV: begin
                    r_rep <= 1'b0;
                    if (48'(w_mp) > {24'd0, r_seg}) begin
                        r_pend  <= 1'b1;
                        r_state <= S_TK_FIN;
                    end else if (r_seg == '0) begin
                        r_last_t <= r_org_t;
                        r_last_f <= r_org_f;
                        r_state  <= S_TK_FIN;
                    end else begin
                        r_state <= S_TK_DW;
                    end
                end
                S_TK_DW: if (w_done) begin
                    r_s     <= w_res[16:0];
                    r_state <= S_TK_S2;
                end
                S_TK_S2: r_state <= S_TK_S3;
                S_TK_S3: begin
                    r_inner <= 21'sd655360 - 21'(r_s) * 21'sd15
                               + 21'(w_sh[16:0]) * 21'sd6;
                    r_state <= S_TK_B;
                end
                S_TK_B: r_state <= S_TK_DT;
                S_TK_DT: begin
                    r_b     <= w_sh[23:0];
                    r_state <= S_TK_DF;
                end
                S_TK_DF: begin
                    r_last_t <= sat16(41'(r_org_t) + 41'(w_mp >>> TimeBits));
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    r_last_f <= sat16(41'(r_org_f) + 41'(w_mp >>> TimeBits));
                    r_state  <= S_TK_FIN;
                end
                S_TK_FIN: begin
                    if (r_rep) r_seg <= (r_tmax > 40'(SegMax)) ? SegMax : r_tmax[23:0];
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        o_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_TK_DF-S_OUT compute the two commands from the multiplier output
    assign o_turn_command    = r_last_t;
    assign o_forward_command = r_last_f;
    assign o_replanned       = r_rep;
endmodule

// ===== sv/qvp_checker.sv =====
module qvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_turn_command,
    input logic        o_replanned
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_turn_command))
        else $error("result dropped under stall");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input open while result pending");
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_replanned |-> $stable(o_turn_command))
        else $error("replan tick changed command");
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("valid after reset");
endmodule

bind quintic_velocity_profile qvp_checker u_chk (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready,
    .o_turn_command, .o_replanned
);
